// ===== hdl/tsds_pkg.sv =====
// Shared types, constants and lookup tables for the temperature display scan block.
package tsds_pkg;

   localparam int unsigned NUM_POS = 8;
   localparam int unsigned POS_W = 3;
   localparam int unsigned CODE_W = 4;

   localparam logic [CODE_W-1:0] CODE_MINUS = 4'd10;
   localparam logic [CODE_W-1:0] CODE_BLANK = 4'd11;
   localparam logic [CODE_W-1:0] CODE_ZERO = 4'd0;
   localparam logic [POS_W-1:0] POINT_POSITION = 3'd3;
   localparam logic [POS_W-1:0] BLANK_POSITION = 3'd1;
   localparam logic [POS_W-1:0] SIGN_POSITION = 3'd0;

   typedef logic [CODE_W-1:0] code_array_type [NUM_POS];
   typedef logic [7:0] bcd_table_type [256];
   typedef logic [6:0] wrap_table_type [64];

   // four fractional decimal digits of frac * 625, packed BCD
   localparam logic [15:0] FRAC_BCD [16] = '{
      16'h0000, 16'h0625, 16'h1250, 16'h1875, 16'h2500, 16'h3125, 16'h3750, 16'h4375,
      16'h5000, 16'h5625, 16'h6250, 16'h6875, 16'h7500, 16'h8125, 16'h8750, 16'h9375
   };

   // packed BCD of (i mod 100) for every 8-bit i
   function automatic bcd_table_type build_mod100_bcd();
      bcd_table_type t;
      logic [3:0] tens;
      logic [3:0] units;
      tens = 4'd0;
      units = 4'd0;
      for (int i = 0; i < 256; i++) begin
         t[i] = {tens, units};
         if (units == 4'd9) begin
            units = 4'd0;
            tens = (tens == 4'd9) ? 4'd0 : tens + 4'd1;
         end else begin
            units = units + 4'd1;
         end
      end
      return t;
   endfunction

   // (i * 64) mod 100 for every 6-bit i
   function automatic wrap_table_type build_wrap64();
      wrap_table_type t;
      logic [7:0] v;
      v = 8'd0;
      for (int i = 0; i < 64; i++) begin
         t[i] = v[6:0];
         v = v + 8'd64;
         if (v >= 8'd100) begin
            v = v - 8'd100;
         end
      end
      return t;
   endfunction

   localparam bcd_table_type MOD100_BCD = build_mod100_bcd();
   localparam wrap_table_type WRAP64 = build_wrap64();

   // common-cathode pattern, bits 0-6 = a-g
   function automatic logic [6:0] seg_of(input logic [CODE_W-1:0] code);
      logic [6:0] s;
      case (code)
         4'd0: s = 7'h3f;
         4'd1: s = 7'h06;
         4'd2: s = 7'h5b;
         4'd3: s = 7'h4f;
         4'd4: s = 7'h66;
         4'd5: s = 7'h6d;
         4'd6: s = 7'h7d;
         4'd7: s = 7'h07;
         4'd8: s = 7'h7f;
         4'd9: s = 7'h6f;
         CODE_MINUS: s = 7'h40;
         default: s = 7'h00;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/tsds_channels.sv =====
// Valid/ready channel interfaces for the request and response words.
interface tsds_req_if;
   logic valid;
   logic ready;
   logic mode;
   logic signed [15:0] reading;

   modport source (output valid, output mode, output reading, input ready);
   modport sink (input valid, input mode, input reading, output ready);
endinterface

interface tsds_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] digit_select;
   logic [7:0] segments;

   modport source (output valid, output digit_select, output segments, input ready);
   modport sink (input valid, input digit_select, input segments, output ready);
endinterface

// ===== hdl/temperature_segment_display_scan.sv =====
// Temperature display scan: stores decimal digits of readings, emits one lit digit per tick.
// A tick word passes from the input register to the output register, which drives rsp.
// Throughput: one request word per cycle while no tick waits on a full output register;
// the input and output registers form a two-stage pipe, and a reading leaves the input
// register without waiting on rsp and updates the digit codes when it leaves.
// Synchronous reset: scan position 0, positions 0-2 blank, 3-7 zero, both stages empty.
module temperature_segment_display_scan (
   input logic clock,
   input logic reset,
   tsds_req_if.sink req_ch,
   tsds_rsp_if.source rsp_ch
);

   // input register
   logic s1_valid_ff, s1_valid_in;
   logic s1_mode_ff;
   logic signed [15:0] s1_reading_ff;

   // state
   tsds_pkg::code_array_type codes_ff, codes_in;
   logic [tsds_pkg::POS_W-1:0] scan_pos_ff, scan_pos_in;

   // output register
   logic out_valid_ff, out_valid_in;
   logic [7:0] digit_select_ff, digit_select_in;
   logic [7:0] segments_ff, segments_in;

   logic s1_advance;
   logic tick_fire;
   logic read_fire;
   logic req_fire;

   logic negative;
   logic [16:0] mag;
   logic [11:0] whole;
   logic [7:0] wrap_sum;
   logic [7:0] whole_bcd;
   logic [15:0] frac_bcd;
   logic [6:0] seg_base;

   assign s1_advance = s1_valid_ff && (s1_mode_ff || !out_valid_ff || rsp_ch.ready);
   assign tick_fire = s1_advance && !s1_mode_ff;
   assign read_fire = s1_advance && s1_mode_ff;
   assign req_ch.ready = !s1_valid_ff || s1_advance;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_advance);

   // magnitude * 625 = whole * 10000 + frac * 625, so only whole mod 100 survives
   assign negative = s1_reading_ff[15];
   assign mag = negative ? (17'h10000 - {1'b0, s1_reading_ff}) : {1'b0, s1_reading_ff};
   assign whole = mag[15:4];
   assign wrap_sum = {1'b0, tsds_pkg::WRAP64[whole[11:6]]} + {2'b00, whole[5:0]};
   assign whole_bcd = tsds_pkg::MOD100_BCD[wrap_sum];
   assign frac_bcd = tsds_pkg::FRAC_BCD[mag[3:0]];

   always_comb begin
      codes_in = codes_ff;
      if (read_fire) begin
         codes_in[0] = negative ? tsds_pkg::CODE_MINUS : tsds_pkg::CODE_BLANK;
         codes_in[2] = whole_bcd[7:4];
         codes_in[3] = whole_bcd[3:0];
         codes_in[4] = frac_bcd[15:12];
         codes_in[5] = frac_bcd[11:8];
         codes_in[6] = frac_bcd[7:4];
         codes_in[7] = frac_bcd[3:0];
      end
   end

   assign scan_pos_in = tick_fire ? scan_pos_ff + 3'd1 : scan_pos_ff;
   assign seg_base = tsds_pkg::seg_of(codes_ff[scan_pos_ff]);

   always_comb begin
      digit_select_in = digit_select_ff;
      segments_in = segments_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (tick_fire) begin
         out_valid_in = 1'b1;
         digit_select_in = ~(8'd1 << scan_pos_ff);
         segments_in = {(scan_pos_ff == tsds_pkg::POINT_POSITION), seg_base};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         scan_pos_ff <= '0;
         for (int p = 0; p < tsds_pkg::NUM_POS; p++) begin
            codes_ff[p] <= (p < 3) ? tsds_pkg::CODE_BLANK : tsds_pkg::CODE_ZERO;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         scan_pos_ff <= scan_pos_in;
         codes_ff <= codes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_mode_ff <= req_ch.mode;
         s1_reading_ff <= req_ch.reading;
      end
      digit_select_ff <= digit_select_in;
      segments_ff <= segments_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.digit_select = digit_select_ff;
   assign rsp_ch.segments = segments_ff;

   // a tick moves the scan position by exactly one
   assert property (@(posedge clock) disable iff (reset)
      tick_fire |=> scan_pos_ff == 3'($past(scan_pos_ff) + 3'd1))
      else $error("scan position did not advance on tick");

   // a reading never moves the scan or creates a response word
   assert property (@(posedge clock) disable iff (reset)
      (read_fire && !out_valid_ff) |=> ($stable(scan_pos_ff) && !out_valid_ff))
      else $error("reading disturbed scan or produced a word");

   // exactly one digit lit
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(~digit_select_ff))
      else $error("digit select not one-hot low");

   // position 1 is never written
   assert property (@(posedge clock) disable iff (reset)
      codes_ff[tsds_pkg::BLANK_POSITION] == tsds_pkg::CODE_BLANK)
      else $error("position 1 not blank");

   // sign position only holds minus or blank
   assert property (@(posedge clock) disable iff (reset)
      codes_ff[tsds_pkg::SIGN_POSITION] == tsds_pkg::CODE_MINUS ||
      codes_ff[tsds_pkg::SIGN_POSITION] == tsds_pkg::CODE_BLANK)
      else $error("bad sign code");

endmodule

// ===== bench/temperature_segment_display_scan_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the temperature display scan block, with a digit predictor.
module temperature_segment_display_scan_tb;

   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_READING = 1'b1;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_WORDS = 400;

   typedef struct packed {
      logic [7:0] digit_select;
      logic [7:0] segments;
   } lit_digit_type;

   logic clock;
   logic reset;

   tsds_req_if req_ch ();
   tsds_rsp_if rsp_ch ();

   temperature_segment_display_scan dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   // predicted display contents and scan pointer
   logic [tsds_pkg::CODE_W-1:0] shown_codes [tsds_pkg::NUM_POS];
   logic [tsds_pkg::POS_W-1:0] scan_pos;
   lit_digit_type lit_digits_due [$];

   int mismatches;
   int send_gap_pct;
   int recv_gap_pct;
   int hold_off_left;
   int cycle_count;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [6:0] seg_pattern(input logic [tsds_pkg::CODE_W-1:0] code);
      logic [6:0] pattern;
      case (code)
         4'd0: pattern = 7'h3f;
         4'd1: pattern = 7'h06;
         4'd2: pattern = 7'h5b;
         4'd3: pattern = 7'h4f;
         4'd4: pattern = 7'h66;
         4'd5: pattern = 7'h6d;
         4'd6: pattern = 7'h7d;
         4'd7: pattern = 7'h07;
         4'd8: pattern = 7'h7f;
         4'd9: pattern = 7'h6f;
         tsds_pkg::CODE_MINUS: pattern = 7'h40;
         default: pattern = 7'h00;
      endcase
      return pattern;
   endfunction

   // reading * 625 = temperature in 0.0001 degree; keep the low six decimal digits
   function automatic void store_reading(input logic signed [15:0] value);
      logic [16:0] magnitude;
      logic [24:0] scaled;
      magnitude = value[15] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
      scaled = magnitude * 25'd625;
      for (int p = tsds_pkg::NUM_POS - 1; p > int'(tsds_pkg::BLANK_POSITION); p--) begin
         shown_codes[p] = tsds_pkg::CODE_W'(scaled % 25'd10);
         scaled = scaled / 25'd10;
      end
      shown_codes[tsds_pkg::SIGN_POSITION] = value[15] ? tsds_pkg::CODE_MINUS
                                                       : tsds_pkg::CODE_BLANK;
   endfunction

   function automatic lit_digit_type light_next_digit();
      lit_digit_type d;
      d.digit_select = ~(8'b1 << scan_pos);
      d.segments = {scan_pos == tsds_pkg::POINT_POSITION, seg_pattern(shown_codes[scan_pos])};
      scan_pos = scan_pos + 1'b1;
      return d;
   endfunction

   task automatic note_mismatch(input string what, input logic [7:0] want,
                                input logic [7:0] got);
      if (mismatches < MAX_REPORTS) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
      mismatches++;
   endtask

   // prediction on accepted requests, checking on accepted responses
   always @(posedge clock) begin
      lit_digit_type want;
      if (reset) begin
         for (int p = 0; p < tsds_pkg::NUM_POS; p++) begin
            shown_codes[p] = (p < int'(tsds_pkg::POINT_POSITION)) ? tsds_pkg::CODE_BLANK
                                                                   : tsds_pkg::CODE_ZERO;
         end
         scan_pos = '0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (lit_digits_due.size() == 0) begin
               if (mismatches < MAX_REPORTS) begin
                  $display("%0t: response word with none expected: %h %h", $time,
                           rsp_ch.digit_select, rsp_ch.segments);
               end
               mismatches++;
            end else begin
               want = lit_digits_due.pop_front();
               if (rsp_ch.digit_select !== want.digit_select) begin
                  note_mismatch("digit_select", want.digit_select, rsp_ch.digit_select);
               end
               if (rsp_ch.segments !== want.segments) begin
                  note_mismatch("segments", want.segments, rsp_ch.segments);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.mode == MODE_READING) begin
               store_reading(req_ch.reading);
            end else begin
               lit_digits_due.push_back(light_next_digit());
            end
         end
      end
   end

   // response side: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left = hold_off_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send_word(input logic mode, input logic signed [15:0] value);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.reading <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_word(MODE_TICK, 16'($urandom));
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (lit_digits_due.size() != 0) @(posedge clock);
   endtask

   // full sweep of the reset contents: blanks, zeros and the point
   task automatic test_power_up_display();
      send_ticks(tsds_pkg::NUM_POS);
   endtask

   task automatic test_directed_readings();
      send_word(MODE_READING, -16'sd32768);
      send_ticks(tsds_pkg::NUM_POS);
      // back-to-back readings; 1600 * 625 wraps to all zeros
      send_word(MODE_READING, 16'sd32767);
      send_word(MODE_READING, 16'sd1600);
      send_ticks(tsds_pkg::NUM_POS / 2);
      send_word(MODE_READING, -16'sd1);
      send_ticks(tsds_pkg::NUM_POS / 2);
   endtask

   task automatic test_random_traffic(input int count);
      logic signed [15:0] value;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            case ($urandom_range(9))
               0: value = 16'sh8000;
               1: value = 16'sh7fff;
               2: value = 16'sh0000;
               3: value = -16'sd1;
               default: value = 16'($urandom);
            endcase
            send_word(MODE_READING, value);
         end else begin
            send_word(MODE_TICK, 16'($urandom));
         end
      end
   endtask

   // receiver holds off while ticks keep coming, so both stages fill and req stalls
   task automatic test_back_pressure();
      hold_off_left = 200;
      send_ticks(20);
      send_word(MODE_READING, 16'($urandom));
      send_ticks(20);
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_TICK;
      req_ch.reading = '0;
      rsp_ch.ready = 1'b0;
      mismatches = 0;
      hold_off_left = 0;
      cycle_count = 0;
      send_gap_pct = 33;
      recv_gap_pct = 78;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_power_up_display();
      test_directed_readings();
      test_random_traffic(PHASE_WORDS);
      wait_for_drain();

      send_gap_pct = 78;
      recv_gap_pct = 33;
      test_random_traffic(PHASE_WORDS);
      wait_for_drain();

      send_gap_pct = 0;
      recv_gap_pct = 0;
      test_random_traffic(PHASE_WORDS);
      test_back_pressure();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && lit_digits_due.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== temperature_segment_display_scan.f =====
hdl/tsds_pkg.sv
hdl/tsds_channels.sv
hdl/temperature_segment_display_scan.sv
bench/temperature_segment_display_scan_tb.sv
